@@ sv/isrs_pkg.sv @@
// ----------------------------------------------------------------------------
// isrs_pkg: shared types and constants of the I2C sensor register reader
// Control flag masks, bus event codes and the sequencer state record.
// ----------------------------------------------------------------------------
package isrs_pkg;

  // Control flag bits of the I2C controller.
  localparam logic [3:0] FL_NONE = 4'h0;
  localparam logic [3:0] FL_STA  = 4'h1;
  localparam logic [3:0] FL_STO  = 4'h2;
  localparam logic [3:0] FL_SI   = 4'h4;
  localparam logic [3:0] FL_AA   = 4'h8;

  // Word kinds on the input side.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_EVENT = 1'b1;

  // Bus status event codes.
  typedef enum logic [3:0] {
    EV_START_SENT = 4'd0,
    EV_REP_START  = 4'd1,
    EV_SLAW_ACK   = 4'd2,
    EV_SLAW_NACK  = 4'd3,
    EV_DATA_ACK   = 4'd4,
    EV_DATA_NACK  = 4'd5,
    EV_ARB_LOST   = 4'd6,
    EV_SLAR_ACK   = 4'd7,
    EV_RX_ACK     = 4'd8,
    EV_RX_NACK    = 4'd9,
    EV_STOP_RCVD  = 4'd10,
    EV_OTHER      = 4'd11
  } event_t;

  // Fields of one input word.
  typedef struct packed {
    logic       action;
    logic [3:0] event_req;
    logic [7:0] rx_byte;
    logic [6:0] slave_addr;
    logic [1:0] write_count;
    logic [7:0] first_reg;
    logic [7:0] second_reg;
    logic [2:0] first_reads;
    logic [2:0] second_reads;
  } item_t;

  // Fields of one result word.
  typedef struct packed {
    logic [3:0] ctrl_set;
    logic [3:0] ctrl_clear;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [2:0] rx_index;
    logic [7:0] rx_data;
    logic       done_res;
  } result_t;

  // Transaction context held between words.
  typedef struct packed {
    logic [6:0]      target_addr;
    logic [1:0]      writes_left;
    logic [1:0][7:0] pointer_bytes;
    logic [1:0][2:0] reads_left;
    logic            pointer_index;
  } seq_state_t;

  // Counter commands from the decoder to the top level.
  typedef struct packed {
    logic load;
    logic ptr_adv;
    logic store_adv;
  } step_ctl_t;

endpackage

@@ sv/isrs_decode.sv @@
// ----------------------------------------------------------------------------
// isrs_decode: per-word decode of the register read sequencer
// Maps one input word and the current context to a result and a new context.
// ----------------------------------------------------------------------------
module isrs_decode
  import isrs_pkg::*;
(
  input  item_t      item,
  input  seq_state_t st,
  input  logic [2:0] store_pos,
  output result_t    res,
  output seq_state_t st_next,
  output step_ctl_t  ctl
);

  logic       p;
  logic [2:0] r;
  logic [2:0] r_dec;

  assign p     = st.pointer_index;
  assign r     = st.reads_left[p];
  assign r_dec = (r != 3'd0) ? r - 3'd1 : 3'd0;

  always_comb begin
    res     = '0;
    st_next = st;
    ctl     = '0;
    if (item.action == ACT_START) begin
      st_next.target_addr      = item.slave_addr;
      st_next.writes_left      = item.write_count;
      st_next.pointer_bytes[0] = item.first_reg;
      st_next.pointer_bytes[1] = item.second_reg;
      st_next.reads_left[0]    = item.first_reads;
      st_next.reads_left[1]    = item.second_reads;
      st_next.pointer_index    = 1'b0;
      ctl.load                 = 1'b1;
      res.ctrl_set             = FL_STA;
      res.ctrl_clear           = FL_AA | FL_SI | FL_STA | FL_STO;
    end else begin
      case (event_t'(item.event_req))
        EV_START_SENT: begin
          res.ctrl_clear = FL_SI | FL_STA;
          res.tx_valid   = 1'b1;
          res.tx_byte    = {st.target_addr, 1'b0};
        end
        EV_REP_START: begin
          res.ctrl_clear = FL_SI | FL_STA;
          res.tx_valid   = 1'b1;
          res.tx_byte    = {st.target_addr, 1'b1};
        end
        EV_SLAW_ACK: begin
          if (st.writes_left != 2'd0) begin
            st_next.writes_left = st.writes_left - 2'd1;
          end
          res.ctrl_clear = FL_STA | FL_STO | FL_SI;
          res.tx_valid   = 1'b1;
          res.tx_byte    = st.pointer_bytes[p];
        end
        EV_DATA_ACK: begin
          // Pointer sent: restart for reading, or stop if nothing to read.
          if (r != 3'd0) begin
            res.ctrl_set   = FL_STA;
            res.ctrl_clear = FL_SI;
          end else begin
            res.ctrl_set   = FL_STO;
            res.ctrl_clear = FL_STA | FL_SI;
          end
        end
        EV_SLAR_ACK: begin
          if (r > 3'd1) begin
            res.ctrl_set   = FL_AA;
            res.ctrl_clear = FL_STA | FL_STO | FL_SI;
          end else begin
            res.ctrl_clear = FL_AA | FL_STA | FL_STO | FL_SI;
          end
        end
        EV_RX_ACK: begin
          ctl.store_adv         = 1'b1;
          st_next.reads_left[p] = r_dec;
          res.rx_valid          = 1'b1;
          res.rx_index          = store_pos;
          res.rx_data           = item.rx_byte;
          if (r_dec > 3'd1) begin
            res.ctrl_set   = FL_AA;
            res.ctrl_clear = FL_STA | FL_STO | FL_SI;
          end else begin
            res.ctrl_clear = FL_AA | FL_STA | FL_STO | FL_SI;
          end
        end
        EV_RX_NACK: begin
          ctl.store_adv         = 1'b1;
          st_next.reads_left[p] = r_dec;
          res.rx_valid          = 1'b1;
          res.rx_index          = store_pos;
          res.rx_data           = item.rx_byte;
          if (st.writes_left != 2'd0) begin
            // Another pointer follows: stop and start again.
            ctl.ptr_adv    = 1'b1;
            res.ctrl_set   = FL_STO | FL_STA;
            res.ctrl_clear = FL_SI;
          end else begin
            res.ctrl_set   = FL_STO;
            res.ctrl_clear = FL_STA | FL_SI;
            res.done_res   = 1'b1;
          end
        end
        EV_STOP_RCVD: begin
          res.ctrl_set   = FL_AA;
          res.ctrl_clear = FL_SI;
        end
        EV_DATA_NACK, EV_ARB_LOST: begin
          res.ctrl_set   = FL_STO;
          res.ctrl_clear = FL_SI;
        end
        default: begin
          res.ctrl_clear = FL_SI;
        end
      endcase
    end
  end

endmodule

@@ sv/i2c_sensor_register_read_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_sensor_register_read_sequencer: I2C register read command sequencer
// Turns start words and bus status events into controller flag commands.
// ----------------------------------------------------------------------------
// Usage notes.
// The slave side (s_*) takes one word per handshake. s_tuser selects the kind
// of word: a start word loads the sensor address, the number of register
// pointers, the pointer bytes and the read count for each pointer; an event
// word reports one status code of the I2C controller with its received byte.
// Every accepted word yields exactly one result word on the master side
// (m_*): flag set and clear masks, an optional byte to transmit and an
// optional received byte with its storage position. m_tlast marks the word
// that carries the final byte of the transaction.
// The decode is a single combinational pass into the result register, so a
// result appears in the cycle after its word is accepted, and one word can be
// accepted in every cycle. The result register is the only buffer: while it
// holds an untaken word and the receiver stalls m_tready, s_tready drops; it
// rises again in the cycle the result is taken, so no bubble is inserted.
// Reset clears the transaction context, the pointer and storage counters and
// the result valid flag; no word is pending after reset.
// ----------------------------------------------------------------------------
module i2c_sensor_register_read_sequencer
  import isrs_pkg::*;
#(
  parameter int MAX_POINTERS = 2,
  parameter int RAW_DEPTH    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // event_req[3:0], rx_byte[11:4], slave_addr[18:12], write_count[20:19],
  // first_reg[28:21], second_reg[36:29], first_reads[39:37],
  // second_reads[42:40], zero fill [47:43]
  input  logic [47:0] s_tdata,
  // action[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ctrl_set[3:0], ctrl_clear[7:4], tx_valid[8], tx_byte[16:9], rx_valid[17],
  // rx_index[20:18], rx_data[28:21], zero fill [31:29]
  output logic [31:0] m_tdata,
  // done_res
  output logic        m_tlast
);

  localparam int         IDX_W      = (RAW_DEPTH > 1) ? $clog2(RAW_DEPTH) : 1;
  localparam logic [IDX_W-1:0] STORE_LAST = IDX_W'(RAW_DEPTH - 1);
  localparam logic       PTR_LAST   = 1'(MAX_POINTERS - 1);

  item_t            item;
  seq_state_t       st;
  seq_state_t       st_next;
  seq_state_t       st_step;
  step_ctl_t        ctl;
  result_t          res_comb;
  result_t          res;
  logic [IDX_W-1:0] store_index;
  logic [IDX_W+2:0] store_ext;
  logic             accept;

  // Unpack the input word.
  assign item.action       = s_tuser[0];
  assign item.event_req    = s_tdata[3:0];
  assign item.rx_byte      = s_tdata[11:4];
  assign item.slave_addr   = s_tdata[18:12];
  assign item.write_count  = s_tdata[20:19];
  assign item.first_reg    = s_tdata[28:21];
  assign item.second_reg   = s_tdata[36:29];
  assign item.first_reads  = s_tdata[39:37];
  assign item.second_reads = s_tdata[42:40];

  // The storage position is reported through a three bit field.
  assign store_ext = {3'b000, store_index};

  isrs_decode u_decode (
    .item      (item),
    .st        (st),
    .store_pos (store_ext[2:0]),
    .res       (res_comb),
    .st_next   (st_next),
    .ctl       (ctl)
  );

  // The pointer slot wraps after the last configured pointer.
  always_comb begin
    st_step = st_next;
    if (ctl.ptr_adv) begin
      st_step.pointer_index = (st.pointer_index == PTR_LAST) ? 1'b0
                                                             : st.pointer_index + 1'b1;
    end
  end

  // A new word may enter whenever the result register is empty or drains now.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '0;
      store_index <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        st       <= st_step;
        m_tvalid <= 1'b1;
        if (ctl.load) begin
          store_index <= '0;
        end else if (ctl.store_adv) begin
          store_index <= (store_index == STORE_LAST) ? '0 : store_index + 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload; only loaded on an accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_comb;
    end
  end

  assign m_tdata = {3'b000, res.rx_data, res.rx_index, res.rx_valid, res.tx_byte,
                    res.tx_valid, res.ctrl_clear, res.ctrl_set};
  assign m_tlast = res.done_res;

endmodule
